// File: hw/rtl/multi_server_queue_wait_core_assert.svh
// Assertion macros for the multi-server queue wait block.
// Used by the port checker; needs clk and rst_n in scope where expanded.
`ifndef MULTI_SERVER_QUEUE_WAIT_CORE_ASSERT_SVH
`define MULTI_SERVER_QUEUE_WAIT_CORE_ASSERT_SVH

// Same-cycle implication, reset masked
`define MSQW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msqw assertion failed");

// Next-cycle implication, reset masked
`define MSQW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msqw assertion failed");

`endif

// File: hw/rtl/msqw_pkg.sv
// Shared types and constants for the multi-server queue wait block.
// No dependencies; imported by every module of the block.
package msqw_pkg;

  localparam int SERVERS_DEF = 16;
  localparam int TICK_W      = 32;
  localparam int SRV_IDX_W   = 4;
  localparam int CFG_W       = 5;

  localparam logic [CFG_W-1:0] ACTIVE_RST = 5'd1;

  typedef struct packed {
    logic [TICK_W-1:0] arrival_time;
    logic [TICK_W-1:0] service_time;
  } in_item_t;

  typedef struct packed {
    logic [TICK_W-1:0]    queue_delay;
    logic [SRV_IDX_W-1:0] server_index;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic update;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_last;
  } dp_sts_t;

endpackage

// File: hw/rtl/msqw_ctrl.sv
// Controller state machine for the multi-server queue wait block.
// Depends on msqw_pkg; drives datapath commands and the handshakes.
module msqw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output msqw_pkg::dp_cmd_t cmd,
  input  msqw_pkg::dp_sts_t sts
);
  import msqw_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  // Result register can take a new item this cycle
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (sts.scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_UPDATE;
      ST_UPDATE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_SCAN:   cmd.scan   = 1'b1;
      ST_DRAIN:  cmd        = '0;
      ST_UPDATE: cmd.update = out_free;
      default:   cmd        = '0;
    endcase
  end

  // Result valid: set on update, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/msqw_datapath.sv
// Datapath: server free-time store, sequential scan and result register.
// Depends on msqw_pkg; steered by msqw_ctrl through dp_cmd_t.
module msqw_datapath #(
  parameter int SERVERS = msqw_pkg::SERVERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  msqw_pkg::in_item_t             in_item,
  input  logic                           cfg_wr_en,
  input  logic [msqw_pkg::CFG_W-1:0]     cfg_wr_data,
  input  msqw_pkg::dp_cmd_t              cmd,
  output msqw_pkg::dp_sts_t              sts,
  output msqw_pkg::out_item_t            out_item
);
  import msqw_pkg::*;

  localparam int IDX_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int CNT_W = $clog2(SERVERS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Free-time store; entries not yet written read as zero
  logic [TICK_W-1:0]  mem [SERVERS];
  logic [SERVERS-1:0] vld_r;

  logic [CFG_W-1:0]  active_r;
  logic [TICK_W-1:0] arrival_r, service_r;
  logic [IDX_W-1:0]  rd_cnt_r;
  logic [TICK_W-1:0] rd_data_r;
  logic              rd_vld_r;
  logic              cmp_en_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              idle_found_r;
  logic [IDX_W-1:0]  idle_idx_r;
  logic [TICK_W-1:0] best_r;
  logic [IDX_W-1:0]  best_idx_r;
  out_item_t         out_item_r;

  logic [CMP_W-1:0]  n_eff;
  logic [IDX_W-1:0]  last_idx;
  logic [TICK_W-1:0] cur_val;
  logic [IDX_W-1:0]  chosen;
  logic [TICK_W-1:0] base;
  logic [TICK_W:0]   sum;
  logic [TICK_W-1:0] new_free;

  // Effective server count, clamped to 1..SERVERS
  always_comb begin
    if (active_r == '0) begin
      n_eff = CMP_W'(1);
    end else if (CMP_W'(active_r) > CMP_W'(SERVERS)) begin
      n_eff = CMP_W'(SERVERS);
    end else begin
      n_eff = CMP_W'(active_r);
    end
  end

  assign last_idx      = IDX_W'(n_eff - CMP_W'(1));
  assign sts.scan_last = (rd_cnt_r == last_idx);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RST;
    end else if (cfg_wr_en) begin
      active_r <= cfg_wr_data;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      arrival_r <= in_item.arrival_time;
      service_r <= in_item.service_time;
    end
  end

  // Read side: one server per cycle, data registered
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data_r <= mem[rd_cnt_r];
      rd_vld_r  <= vld_r[rd_cnt_r];
      cmp_idx_r <= rd_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= '0;
      cmp_en_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.scan;
      if (cmd.start) begin
        rd_cnt_r <= '0;
      end else if (cmd.scan) begin
        rd_cnt_r <= rd_cnt_r + IDX_W'(1);
      end
    end
  end

  assign cur_val = rd_vld_r ? rd_data_r : '0;

  // Compare stage: first idle server and earliest free server
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idle_found_r <= 1'b0;
      idle_idx_r   <= '0;
      best_r       <= '1;
      best_idx_r   <= '0;
    end else if (cmp_en_r) begin
      if (!idle_found_r && (cur_val < arrival_r)) begin
        idle_found_r <= 1'b1;
        idle_idx_r   <= cmp_idx_r;
      end
      if (cur_val < best_r) begin
        best_r     <= cur_val;
        best_idx_r <= cmp_idx_r;
      end
    end
  end

  // Update: pick server, saturating new free time
  assign chosen   = idle_found_r ? idle_idx_r : best_idx_r;
  assign base     = idle_found_r ? arrival_r : best_r;
  assign sum      = {1'b0, base} + {1'b0, service_r};
  assign new_free = sum[TICK_W] ? '1 : sum[TICK_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      mem[chosen] <= new_free;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.update) begin
      vld_r[chosen] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_item_r.queue_delay  <= idle_found_r ? '0 : (best_r - arrival_r);
      out_item_r.server_index <= SRV_IDX_W'(chosen);
    end
  end

  assign out_item = out_item_r;

endmodule

// File: hw/rtl/multi_server_queue_wait_core.sv
// Top level of the multi-server queue wait block.
// Depends on msqw_pkg, msqw_ctrl and msqw_datapath.
//
// Usage:
//   Input channel in_valid / in_stall / in_item carries one customer
//   (arrival and service time). Result channel out_valid / out_stall /
//   out_item returns its wait time and assigned server index, one result
//   per item, in order. cfg_wr_en / cfg_wr_data write the active server
//   count; write it only while the block is idle.
//   The effective active server count N lies in 1..SERVERS. The block
//   takes one item at a time and stalls the input until its result is
//   written back. The scan reads the free-time store through a single
//   read port, one server per cycle, then a drain step for the last
//   compare and an update step for the write-back.
//   A new item is accepted while a finished result still waits in the
//   output register; a stalled receiver holds out_item and the block waits
//   to write back the following item until the register frees.
//   Reset (synchronous, rst_n low) clears all free times to zero and sets
//   the active count to one; no clearing pass is needed.
module multi_server_queue_wait_core #(
  parameter int SERVERS = msqw_pkg::SERVERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  msqw_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output msqw_pkg::out_item_t        out_item,
  input  logic                       cfg_wr_en,
  input  logic [msqw_pkg::CFG_W-1:0] cfg_wr_data
);
  import msqw_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  msqw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Store, scan and result register
  msqw_datapath #(
    .SERVERS (SERVERS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_item    (out_item)
  );

endmodule

// File: hw/rtl/msqw_checker.sv
// Port-level checker for multi_server_queue_wait_core, bound to the top.
// Depends on msqw_pkg and multi_server_queue_wait_core_assert.svh.
`include "multi_server_queue_wait_core_assert.svh"

module msqw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input msqw_pkg::out_item_t out_item
);
  import msqw_pkg::*;

  logic       in_acc, out_acc;
  logic [2:0] pend_r, pend_nxt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Items accepted but not yet delivered
  always_comb begin
    pend_nxt = pend_r + {2'b00, in_acc} - {2'b00, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // One item in the scan at a time
  `MSQW_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall)
  // Held result stays put
  `MSQW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
  // No result without an outstanding item
  `MSQW_ASSERT_NOW(a_no_spurious_out, out_valid, pend_r != 3'd0)
  // At most one item in work plus one in the result register
  `MSQW_ASSERT_NOW(a_pend_bound, 1'b1, pend_r <= 3'd2)

endmodule

bind multi_server_queue_wait_core msqw_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
